// ----- hw/rtl/twlru_pkg.sv -----
// ----------------------------------------------------------------------------
// twlru_pkg
// Shared types for the two-way LRU cache hit checker.
// ----------------------------------------------------------------------------
package twlru_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- hw/rtl/twlru_ram.sv -----
// ----------------------------------------------------------------------------
// twlru_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module twlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/twlru_divider.sv -----
// ----------------------------------------------------------------------------
// twlru_divider
// Division by a fixed divisor through multiplication by its reciprocal.
// The quotient is registered on start and the remainder next, from the
// busy state, when done rises.
// ----------------------------------------------------------------------------
module twlru_divider
  import twlru_pkg::*;
#(
  parameter int DW      = 16,
  parameter int DIVISOR = 2,
  parameter int REM_W   = $clog2(DIVISOR + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  output div_status_t      status,
  output logic [DW-1:0]    quotient,
  output logic [REM_W-1:0] remainder
);

  localparam int SH = DW + $clog2(DIVISOR);
  localparam int PW = SH + DW;
  localparam int RW = DW + 1;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic          busy;
  logic          done;
  logic [DW-1:0] num;
  logic [PW-1:0] prod;
  logic [DW-1:0] back;

  always_comb begin
    prod = PW'(dividend) * PW'(RECIP);
    back = quotient * DW'(DIVISOR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      num      <= dividend;
      quotient <= prod[SH +: DW];
      busy     <= 1'b1;
      done     <= 1'b0;
    end else if (busy) begin
      remainder <= REM_W'(num - back);
      busy      <= 1'b0;
      done      <= 1'b1;
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// ----- hw/rtl/two_way_lru_cache_hit_check.sv -----
// ----------------------------------------------------------------------------
// two_way_lru_cache_hit_check
// Hit/miss classifier for a two-way set-associative cache with LRU refill.
//
// The input channel (in_valid/in_stall) carries one block address per
// transaction, with start_new to clear the cache and the counters first.
// The output channel (out_valid/out_stall) returns one result per input:
// hit flag, way used, and saturating hit and miss counts.
// The address is split into set and tag by a reciprocal multiplication
// in the divider, quotient first and remainder next; one read and one
// write of the set's row in the tag RAM follow, and the result is
// registered with the write. The next input is taken once it is registered.
// With start_new all set rows are swept first, one per cycle.
// After reset a clearing pass over all SETS rows runs before in_stall drops.
// A stalled result holds in the output register while the next input is
// taken; the block then waits with its update until the register is free.
// ----------------------------------------------------------------------------
module two_way_lru_cache_hit_check
  import twlru_pkg::*;
#(
  parameter int SETS       = 2,
  parameter int ADDR_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] block_address,
  input  logic        start_new,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        way_used,
  output logic [15:0] hit_count,
  output logic [15:0] miss_count
);

  localparam longint TAG_MAX = ((64'd1 << ADDR_BITS) - 1) / SETS;
  localparam int TAG_W  = (TAG_MAX > 0) ? $clog2(TAG_MAX + 1) : 1;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int REM_W  = $clog2(SETS + 1);
  localparam int ROW_W  = 2 * TAG_W + 3;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_UPDATE
  } state_t;

  state_t              state;
  logic [SET_W-1:0]    sweep;
  logic                sweep_last;
  logic [COUNT_BITS-1:0] hits;
  logic [COUNT_BITS-1:0] misses;
  logic [COUNT_BITS-1:0] hits_next;
  logic [COUNT_BITS-1:0] misses_next;

  div_status_t         div_status;
  logic [ADDR_BITS-1:0] div_quot;
  logic [REM_W-1:0]    div_rem;
  logic                div_start;

  logic                ram_wr_en;
  logic [SET_W-1:0]    ram_wr_addr;
  logic [ROW_W-1:0]    ram_wr_data;
  logic                ram_rd_en;
  logic [ROW_W-1:0]    ram_rd_data;

  logic [TAG_W-1:0]    cur_tag;
  logic [SET_W-1:0]    cur_set;
  logic [TAG_W-1:0]    tag0;
  logic [TAG_W-1:0]    tag1;
  logic                v0;
  logic                v1;
  logic                rec;
  logic                hit0;
  logic                hit1;
  logic                hit_now;
  logic                way_now;
  logic [ROW_W-1:0]    new_row;
  logic                finish;

  assign in_stall   = (state != S_IDLE);
  assign div_start  = in_valid && !in_stall;
  assign sweep_last = (sweep == SET_W'(SETS - 1));
  assign cur_tag    = div_quot[TAG_W-1:0];
  assign cur_set    = div_rem[SET_W-1:0];
  assign finish     = (state == S_UPDATE) && !(out_valid && out_stall);

  twlru_divider #(
    .DW      (ADDR_BITS),
    .DIVISOR (SETS),
    .REM_W   (REM_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ADDR_BITS'(block_address)),
    .status    (div_status),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    tag0    = ram_rd_data[TAG_W-1:0];
    tag1    = ram_rd_data[2*TAG_W-1:TAG_W];
    v0      = ram_rd_data[2*TAG_W];
    v1      = ram_rd_data[2*TAG_W+1];
    rec     = ram_rd_data[2*TAG_W+2];
    hit0    = v0 && (tag0 == cur_tag);
    hit1    = v1 && (tag1 == cur_tag);
    hit_now = hit0 || hit1;
    if (hit0) begin
      way_now = 1'b0;
    end else if (hit1) begin
      way_now = 1'b1;
    end else if (!v0) begin
      way_now = 1'b0;
    end else if (!v1) begin
      way_now = 1'b1;
    end else begin
      way_now = !rec;
    end
    new_row = ram_rd_data;
    new_row[2*TAG_W+2] = way_now;
    if (!hit_now) begin
      if (way_now) begin
        new_row[2*TAG_W-1:TAG_W] = cur_tag;
        new_row[2*TAG_W+1]       = 1'b1;
      end else begin
        new_row[TAG_W-1:0] = cur_tag;
        new_row[2*TAG_W]   = 1'b1;
      end
    end
    hits_next   = hits;
    misses_next = misses;
    if (hit_now) begin
      if (hits != '1) begin
        hits_next = hits + 1'b1;
      end
    end else begin
      if (misses != '1) begin
        misses_next = misses + 1'b1;
      end
    end
    ram_wr_en   = (state == S_INIT) || (state == S_CLEAR) || finish;
    ram_wr_addr = finish ? cur_set : sweep;
    ram_wr_data = finish ? new_row : '0;
    ram_rd_en   = (state == S_DIV) && div_status.done;
  end

  twlru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (cur_set),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
      hits      <= '0;
      misses    <= '0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT, S_CLEAR: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= (state == S_INIT) ? S_IDLE : S_DIV;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (start_new) begin
              hits   <= '0;
              misses <= '0;
              state  <= S_CLEAR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (finish) begin
            hit        <= hit_now;
            way_used   <= way_now;
            hit_count  <= 16'(hits_next);
            miss_count <= 16'(misses_next);
            hits       <= hits_next;
            misses     <= misses_next;
            state      <= S_IDLE;
          end
        end
        default: begin
          sweep <= '0;
          state <= S_INIT;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/twlru_checker.sv -----
// ----------------------------------------------------------------------------
// twlru_checker
// Port-level checks for the two-way LRU cache hit checker.
// ----------------------------------------------------------------------------
module twlru_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        way_used,
  input logic [15:0] hit_count,
  input logic [15:0] miss_count
);

  // The clearing pass keeps the input side stalled right after reset.
  assert property (@(posedge clk) rst |=> in_stall)
    else $error("input not stalled after reset");

  // Only one transaction is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in flight");

  // A result never appears in the cycle right after an input is taken.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared too early");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(hit) && $stable(way_used)
      && $stable(hit_count) && $stable(miss_count)))
    else $error("stalled result changed");

endmodule

bind two_way_lru_cache_hit_check twlru_checker u_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the two-way LRU cache hit checker.
//
// A scoreboard class keeps its own copy of the cache: tags, valid bits,
// the most recent way of each set and the saturating hit and miss counts.
// Each accepted input transaction is run through it, and the expected
// result is queued. Each accepted output transaction is compared field by
// field with the oldest queued result.
//
// The stimulus has three parts. A directed part covers empty-way fills,
// LRU replacement, extreme addresses and clears. A short run of repeated
// hits to one address follows. Random episodes draw most
// accesses from small address pools, so that hits, evictions and clears
// all occur, with some fully random addresses mixed in. Both sides idle
// in random bursts, except during the repeated-hit run and the final part.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETS       = 2;
  localparam int          WAYS       = 2;
  localparam int          ADDR_BITS  = 16;
  localparam int          COUNT_BITS = 16;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic        hit;
    logic        way_used;
    logic [15:0] hit_count;
    logic [15:0] miss_count;
  } access_result_t;

  class lru_scoreboard;
    logic [15:0]    tag_mem [SETS*WAYS];
    bit             valid_mem [SETS*WAYS];
    bit             last_way [SETS];
    logic [15:0]    hits;
    logic [15:0]    misses;
    access_result_t expected_results[$];
    int             errors;

    function new();
      errors = 0;
      clear_cache();
    endfunction

    function void clear_cache();
      for (int i = 0; i < SETS*WAYS; i++) begin
        tag_mem[i]   = 16'd0;
        valid_mem[i] = 1'b0;
      end
      for (int s = 0; s < SETS; s++) last_way[s] = 1'b0;
      hits   = 16'd0;
      misses = 16'd0;
    endfunction

    function void report(string msg);
      $display("%0t: %s", $time, msg);
      errors++;
    endfunction

    function void note_access(logic [15:0] addr, logic clear_first);
      int             set_idx;
      int             base;
      logic [15:0]    tag;
      access_result_t r;
      set_idx = addr % SETS;
      tag     = 16'(addr / SETS);
      base    = set_idx * WAYS;
      if (clear_first) clear_cache();
      r.hit      = 1'b0;
      r.way_used = 1'b0;
      if (valid_mem[base] && tag_mem[base] == tag) begin
        r.hit = 1'b1;
      end else if (valid_mem[base+1] && tag_mem[base+1] == tag) begin
        r.hit      = 1'b1;
        r.way_used = 1'b1;
      end
      if (r.hit) begin
        if (hits != COUNT_MAX) hits++;
      end else begin
        if (!valid_mem[base]) r.way_used = 1'b0;
        else if (!valid_mem[base+1]) r.way_used = 1'b1;
        else r.way_used = ~last_way[set_idx];
        tag_mem[base + r.way_used]   = tag;
        valid_mem[base + r.way_used] = 1'b1;
        if (misses != COUNT_MAX) misses++;
      end
      last_way[set_idx] = r.way_used;
      r.hit_count  = hits;
      r.miss_count = misses;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic h, logic w, logic [15:0] hc, logic [15:0] mc);
      access_result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf({"result with no access pending: hit=%0b way_used=%0b",
                          " hit_count=%0d miss_count=%0d"}, h, w, hc, mc));
        return;
      end
      e = expected_results.pop_front();
      if (h !== e.hit)
        report($sformatf("hit: expected %0b, actual %0b", e.hit, h));
      if (w !== e.way_used)
        report($sformatf("way_used: expected %0b, actual %0b", e.way_used, w));
      if (hc !== e.hit_count)
        report($sformatf("hit_count: expected %0d, actual %0d", e.hit_count, hc));
      if (mc !== e.miss_count)
        report($sformatf("miss_count: expected %0d, actual %0d", e.miss_count, mc));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] block_address;
  logic        start_new;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic        way_used;
  logic [15:0] hit_count;
  logic [15:0] miss_count;

  int gap_pct   = 0;
  int stall_pct = 0;

  lru_scoreboard sb = new();

  always #4 clk = ~clk;

  two_way_lru_cache_hit_check #(
    .SETS       (SETS),
    .ADDR_BITS  (ADDR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .block_address (block_address),
    .start_new     (start_new),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .way_used      (way_used),
    .hit_count     (hit_count),
    .miss_count    (miss_count)
  );

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      1: begin
        gap_pct   = 10;
        stall_pct = 10;
      end
      2: begin
        gap_pct   = 40;
        stall_pct = 5;
      end
      default: begin
        gap_pct   = 5;
        stall_pct = 40;
      end
    endcase
  endtask

  task automatic send_access(input logic [15:0] addr, input logic clear_first);
    int gap;
    gap = 0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    block_address <= addr;
    start_new     <= clear_first;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_access(addr, clear_first);
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    logic [15:0] pool [6];
    int          pool_size;
    int          episode_left;
    logic [15:0] addr;
    logic        clear_first;
    pool_size    = 1;
    episode_left = 0;
    for (int n = 0; n < count; n++) begin
      clear_first = 1'b0;
      if (allow_idle && n % 64 == 0) pick_idling();
      if (episode_left == 0) begin
        pool_size = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++) pool[i] = 16'($urandom_range(0, 65535));
        episode_left = $urandom_range(20, 80);
        clear_first  = ($urandom_range(0, 2) == 0);
      end
      episode_left--;
      if ($urandom_range(0, 99) < 85) addr = pool[$urandom_range(0, pool_size - 1)];
      else addr = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 149) == 0) clear_first = 1'b1;
      send_access(addr, clear_first);
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_result(hit, way_used, hit_count, miss_count);
      if (stall_left > 0 && stall_pct > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall  <= 1'b1;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int wait_cycles;
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    block_address <= 16'd0;
    start_new     <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    send_access(16'h0000, 1'b1);
    send_access(16'h0000, 1'b0);
    send_access(16'h0002, 1'b0);
    send_access(16'h0000, 1'b0);
    send_access(16'h0004, 1'b0);
    send_access(16'h0002, 1'b0);
    send_access(16'h0004, 1'b0);
    send_access(16'hFFFF, 1'b0);
    send_access(16'hFFFF, 1'b0);
    send_access(16'hFFFD, 1'b0);
    send_access(16'h0001, 1'b0);
    send_access(16'hFFFD, 1'b0);
    send_access(16'hFFFE, 1'b0);
    send_access(16'hAAAA, 1'b0);
    send_access(16'h5555, 1'b0);
    send_access(16'hFFFF, 1'b1);
    send_access(16'h0000, 1'b0);
    send_access(16'hFFFF, 1'b0);
    send_access(16'h0000, 1'b1);
    send_access(16'h0000, 1'b1);

    gap_pct   = 0;
    stall_pct = 0;
    send_access(16'h1234, 1'b1);
    repeat (20) send_access(16'h1234, 1'b0);
    send_access(16'h5678, 1'b0);
    send_access(16'h1234, 1'b0);
    send_access(16'h9ABC, 1'b0);
    send_access(16'h1234, 1'b0);
    send_access(16'h5678, 1'b1);

    run_random(850, 1'b1);
    gap_pct   = 0;
    stall_pct = 0;
    run_random(150, 1'b0);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.expected_results.size() > 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (40) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
